/* src/kalman_displacement_estimator_core_assert.svh */
// Assertion macros shared by the estimator RTL.
// No dependencies; included by the estimator core, which carries the assertions.
`ifndef KALMAN_DISPLACEMENT_ESTIMATOR_CORE_ASSERT_SVH
`define KALMAN_DISPLACEMENT_ESTIMATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KDE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("kde assertion failed");
`define KDE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kde assertion failed");
`else
`define KDE_ASSERT(lbl, clk, rstn, prop)
`define KDE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* src/kde_pkg.sv */
// Shared constants, types and helper functions of the displacement estimator.
// No dependencies; used by every module of the block.
package kde_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM       = 3;
    localparam int DATA_W    = 32;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 52;
    localparam int CFG_W     = 31;
    localparam int DT_W      = 17;
    localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int IDX_W     = $clog2(DIM * DIM);
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_W-1:0] RST_PNOISE = CFG_W'(655);
    localparam logic [CFG_W-1:0] RST_MNOISE = CFG_W'(6554);
    localparam logic [CFG_W-1:0] RST_THRESH = CFG_W'(3277);
    localparam logic [CFG_W-1:0] RST_IVAR   = CFG_W'(65536000);

    localparam logic [CFG_IDX_W-1:0] REG_PNOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MNOISE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IVAR   = CFG_IDX_W'(3);

    typedef struct packed {
        logic issue;
        logic first;
        logic sub;
        logic half;
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx(input logic [1:0] r, input logic [1:0] c);
        return IDX_W'({r, 1'b0}) + IDX_W'(r) + IDX_W'(c);
    endfunction

    function automatic logic signed [OPND_W-1:0] trans(
        input logic [1:0] r, input logic [1:0] c,
        input logic signed [OPND_W-1:0] dt, input logic signed [OPND_W-1:0] h);
        if (r == c) begin
            return OPND_W'(1) <<< FRAC_BITS;
        end else if ((r == 2'd0 && c == 2'd1) || (r == 2'd1 && c == 2'd2)) begin
            return dt;
        end else if (r == 2'd0 && c == 2'd2) begin
            return h;
        end
        return '0;
    endfunction

endpackage

/* src/kde_mac.sv */
// Shared multiply, round and accumulate unit of the estimator.
// Depends on kde_pkg; the product is registered before it is accumulated.
module kde_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kde_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [kde_pkg::OPND_W-1:0]     i_a,
    input  logic signed [kde_pkg::OPND_W-1:0]     i_b,
    input  logic signed [kde_pkg::OPND_W-1:0]     i_init,
    output logic signed [kde_pkg::ACC_W-1:0]      o_acc
);

    logic signed [kde_pkg::PROD_W-1:0] r_prod;
    logic                              r_pend;
    logic                              r_first;
    logic                              r_sub;
    logic                              r_half;
    logic signed [kde_pkg::OPND_W-1:0] r_init;
    logic signed [kde_pkg::ACC_W-1:0]  r_acc;
    logic signed [kde_pkg::PROD_W-1:0] w_rnd_full;
    logic signed [kde_pkg::ACC_W-1:0]  w_rnd;
    logic signed [kde_pkg::ACC_W-1:0]  w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod  <= i_a * i_b;
            r_first <= i_ctl.first;
            r_sub   <= i_ctl.sub;
            r_half  <= i_ctl.half;
            r_init  <= i_init;
        end
    end

    always_comb begin
        if (r_half) begin
            w_rnd_full = (r_prod + (kde_pkg::PROD_W'(1) <<< kde_pkg::FRAC_BITS))
                         >>> (kde_pkg::FRAC_BITS + 1);
        end else begin
            w_rnd_full = (r_prod + (kde_pkg::PROD_W'(1) <<< (kde_pkg::FRAC_BITS - 1)))
                         >>> kde_pkg::FRAC_BITS;
        end
        w_rnd  = w_rnd_full[kde_pkg::ACC_W-1:0];
        w_base = r_first ? kde_pkg::ACC_W'(r_init) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_acc <= r_sub ? (w_base - w_rnd) : (w_base + w_rnd);
        end
    end

    assign o_acc = r_acc;

endmodule

/* src/kde_div.sv */
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Depends on kde_pkg for its widths.
module kde_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kde_pkg::NUM_W-1:0]   i_dividend,
    input  logic [kde_pkg::DEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [kde_pkg::NUM_W-1:0]   o_quot
);

    logic                         r_busy;
    logic                         r_done;
    logic [kde_pkg::CNT_W-1:0]    r_cnt;
    logic [kde_pkg::DEN_W-1:0]    r_rem;
    logic [kde_pkg::DEN_W-1:0]    r_den;
    logic [kde_pkg::NUM_W-1:0]    r_quo;
    logic [kde_pkg::DEN_W:0]      w_trial;
    logic [kde_pkg::DEN_W+1:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[kde_pkg::NUM_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kde_pkg::CNT_W'(kde_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kde_pkg::CNT_W'(1);
                if (r_cnt == kde_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[kde_pkg::DEN_W+1]) begin
                r_rem <= w_diff[kde_pkg::DEN_W-1:0];
                r_quo <= {r_quo[kde_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[kde_pkg::DEN_W-1:0];
                r_quo <= {r_quo[kde_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* src/kalman_displacement_estimator_core.sv */
// Kalman displacement estimator: one beat in, one beat out; a new input beat is taken only
// once the result of the previous one has been accepted (also when the update is skipped).
// Prediction and update run on the shared multiply-accumulate unit, and the three gain
// divisions run on the bit-serial divider. Input beats and register writes are taken only
// while idle. Synchronous active-low reset clears the state, loads the register defaults
// and the default covariance diagonal.
`include "kalman_displacement_estimator_core_assert.svh"
module kalman_displacement_estimator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // accel_sample [31:0], time_step [48:32], zero fill [55:49]
    input  logic [55:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // position_est [31:0], velocity_est [63:32], accel_est [95:64]
    output logic [95:0]                     m_axis_tdata,
    // stationary [0], update_skipped [1]
    output logic [1:0]                      m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kde_pkg::CFG_W-1:0]       i_cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_HALF     = 13'b0000000000010,
        ST_PRED_POS = 13'b0000000000100,
        ST_PRED_VEL = 13'b0000000001000,
        ST_FP       = 13'b0000000010000,
        ST_PP       = 13'b0000000100000,
        ST_SVAR     = 13'b0000001000000,
        ST_DIV      = 13'b0000010000000,
        ST_INNOV    = 13'b0000100000000,
        ST_UPD_X    = 13'b0001000000000,
        ST_UPD_P    = 13'b0010000000000,
        ST_ZERO_V   = 13'b0100000000000,
        ST_OUT      = 13'b1000000000000
    } t_state;

    localparam int DW = kde_pkg::DATA_W;
    localparam int OW = kde_pkg::OPND_W;

    t_state                         r_state;
    logic [1:0]                     r_i;
    logic [1:0]                     r_j;
    logic [2:0]                     r_k;
    logic [kde_pkg::CFG_W-1:0]      r_pnoise;
    logic [kde_pkg::CFG_W-1:0]      r_mnoise;
    logic [kde_pkg::CFG_W-1:0]      r_thresh;
    logic signed [DW-1:0]           r_pos;
    logic signed [DW-1:0]           r_vel;
    logic signed [DW-1:0]           r_acc;
    logic signed [DW-1:0]           r_p [0:8];
    logic signed [DW-1:0]           r_fp [0:8];
    logic signed [DW-1:0]           r_gain [0:2];
    logic signed [DW-1:0]           r_meas;
    logic [kde_pkg::DT_W-1:0]       r_dt;
    logic signed [OW-1:0]           r_h;
    logic [DW-1:0]                  r_s;
    logic signed [DW-1:0]           r_innov;
    logic                           r_neg;
    logic                           r_skip;
    logic                           r_out_valid;
    logic [95:0]                    r_out_data;
    logic [1:0]                     r_out_user;

    kde_pkg::t_mac_ctl              w_ctl;
    logic signed [OW-1:0]           w_a;
    logic signed [OW-1:0]           w_b;
    logic signed [OW-1:0]           w_init;
    logic [2:0]                     w_n;
    logic                           w_mac;
    logic                           w_store;
    logic [1:0]                     w_kk;
    logic [kde_pkg::IDX_W-1:0]      w_p_ra;
    logic [kde_pkg::IDX_W-1:0]      w_ij;
    logic signed [DW-1:0]           w_p_rd;
    logic signed [DW-1:0]           w_fp_rd;
    logic signed [OW-1:0]           w_dt;
    logic signed [kde_pkg::ACC_W-1:0] w_macc;
    logic signed [DW-1:0]           w_sat;
    logic signed [DW+1:0]           w_svar;
    logic [DW-1:0]                  w_pmag;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [kde_pkg::NUM_W-1:0]      w_dividend;
    logic [kde_pkg::NUM_W-1:0]      w_quot;
    logic signed [DW-1:0]           w_gain;
    logic signed [DW:0]             w_diff;
    logic [DW-1:0]                  w_mag;
    logic                           w_still;
    logic                           w_cfg_wr;
    logic                           w_last_i;
    logic                           w_last_j;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign w_dt     = OW'(r_dt);
    assign w_kk     = (r_k[1:0] == 2'd3) ? 2'd2 : r_k[1:0];
    assign w_ij     = kde_pkg::idx(r_i, r_j);
    assign w_last_i = (r_i == 2'd2);
    assign w_last_j = (r_j == 2'd2);
    assign w_fp_rd  = r_fp[kde_pkg::idx(r_i, w_kk)];
    assign w_p_rd   = r_p[w_p_ra];
    assign w_sat    = kde_pkg::sat32(w_macc);
    assign w_store  = w_mac && (r_k == w_n + 3'd1);

    always_comb begin
        w_p_ra = kde_pkg::idx(2'd2, 2'd2);
        case (r_state)
            ST_FP:   w_p_ra = kde_pkg::idx(w_kk, r_j);
            ST_UPD_P: w_p_ra = (r_k == 3'd0) ? w_ij : kde_pkg::idx(2'd2, r_j);
            ST_DIV:  w_p_ra = kde_pkg::idx(r_i, 2'd2);
            default: w_p_ra = kde_pkg::idx(2'd2, 2'd2);
        endcase
    end

    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_init = '0;
        w_n    = 3'd1;
        w_mac  = 1'b1;
        w_ctl  = '0;
        case (r_state)
            ST_HALF: begin
                w_a       = w_dt;
                w_b       = w_dt;
                w_ctl.half = 1'b1;
            end
            ST_PRED_POS: begin
                w_n    = 3'd2;
                w_init = OW'(r_pos);
                w_a    = (r_k == 3'd0) ? OW'(r_vel) : OW'(r_acc);
                w_b    = (r_k == 3'd0) ? w_dt : r_h;
            end
            ST_PRED_VEL: begin
                w_init = OW'(r_vel);
                w_a    = OW'(r_acc);
                w_b    = w_dt;
            end
            ST_FP: begin
                w_n = 3'd3;
                w_a = kde_pkg::trans(r_i, w_kk, w_dt, r_h);
                w_b = OW'(w_p_rd);
            end
            ST_PP: begin
                w_n    = 3'd3;
                w_init = (r_i == r_j) ? OW'({1'b0, r_pnoise}) : '0;
                w_a    = OW'(w_fp_rd);
                w_b    = kde_pkg::trans(r_j, w_kk, w_dt, r_h);
            end
            ST_UPD_X: begin
                case (r_i)
                    2'd0:    w_init = OW'(r_pos);
                    2'd1:    w_init = OW'(r_vel);
                    default: w_init = OW'(r_acc);
                endcase
                w_a = OW'(r_gain[r_i]);
                w_b = OW'(r_innov);
            end
            ST_UPD_P: begin
                w_n       = 3'd2;
                w_a       = (r_k == 3'd0) ? (OW'(1) <<< kde_pkg::FRAC_BITS) : OW'(r_gain[r_i]);
                w_b       = OW'(w_p_rd);
                w_ctl.sub = (r_k != 3'd0);
            end
            default: begin
                w_mac = 1'b0;
            end
        endcase
        w_ctl.issue = w_mac && (r_k < w_n);
        w_ctl.first = (r_k == 3'd0);
    end

    kde_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_init  (w_init),
        .o_acc   (w_macc)
    );

    always_comb begin
        w_svar      = (DW+2)'(r_p[kde_pkg::idx(2'd2, 2'd2)]) + (DW+2)'({1'b0, r_mnoise});
        w_pmag      = w_p_rd[DW-1] ? (~w_p_rd + DW'(1)) : w_p_rd;
        w_dividend  = {w_pmag, {(kde_pkg::FRAC_BITS+1){1'b0}}} + kde_pkg::NUM_W'(r_s);
        w_div_start = (r_state == ST_DIV) && (r_k == 3'd0);
        if (r_neg) begin
            w_gain = (w_quot > kde_pkg::NUM_W'({1'b1, {(DW-1){1'b0}}}))
                     ? {1'b1, {(DW-1){1'b0}}} : -w_quot[DW-1:0];
        end else begin
            w_gain = (w_quot > kde_pkg::NUM_W'({1'b0, {(DW-1){1'b1}}}))
                     ? {1'b0, {(DW-1){1'b1}}} : w_quot[DW-1:0];
        end
        w_diff  = (DW+1)'(r_meas) - (DW+1)'(r_acc);
        w_mag   = r_meas[DW-1] ? (~r_meas + DW'(1)) : r_meas;
        w_still = (w_mag < {1'b0, r_thresh});
    end

    kde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  ({r_s, 1'b0}),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_pnoise    <= kde_pkg::RST_PNOISE;
            r_mnoise    <= kde_pkg::RST_MNOISE;
            r_thresh    <= kde_pkg::RST_THRESH;
            r_pos       <= '0;
            r_vel       <= '0;
            r_acc       <= '0;
            for (int n = 0; n < 9; n++) begin
                r_p[n] <= (n % 4 == 0) ? DW'(kde_pkg::RST_IVAR) : '0;
            end
        end else begin
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    kde_pkg::REG_PNOISE: r_pnoise <= i_cfg_data;
                    kde_pkg::REG_MNOISE: r_mnoise <= i_cfg_data;
                    kde_pkg::REG_THRESH: r_thresh <= i_cfg_data;
                    kde_pkg::REG_IVAR: begin
                        for (int n = 0; n < 9; n++) begin
                            r_p[n] <= (n % 4 == 0) ? DW'(i_cfg_data) : '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (w_mac) begin
                r_k <= w_store ? 3'd0 : (r_k + 3'd1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_meas  <= s_axis_tdata[31:0];
                        r_dt    <= s_axis_tdata[48:32];
                        r_skip  <= 1'b0;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_HALF;
                    end
                end
                ST_HALF: begin
                    if (w_store) begin
                        r_h     <= OW'(w_sat);
                        r_state <= ST_PRED_POS;
                    end
                end
                ST_PRED_POS: begin
                    if (w_store) begin
                        r_pos   <= w_sat;
                        r_state <= ST_PRED_VEL;
                    end
                end
                ST_PRED_VEL: begin
                    if (w_store) begin
                        r_vel   <= w_sat;
                        r_state <= ST_FP;
                    end
                end
                ST_FP: begin
                    if (w_store) begin
                        r_fp[w_ij] <= w_sat;
                        if (w_last_j) begin
                            r_j <= '0;
                            if (w_last_i) begin
                                r_i     <= '0;
                                r_state <= ST_PP;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                ST_PP: begin
                    if (w_store) begin
                        r_p[w_ij] <= w_sat;
                        if (w_last_j) begin
                            r_j <= '0;
                            if (w_last_i) begin
                                r_i     <= '0;
                                r_state <= ST_SVAR;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                ST_SVAR: begin
                    r_k <= '0;
                    if (w_svar <= 0) begin
                        r_skip  <= 1'b1;
                        r_state <= ST_ZERO_V;
                    end else begin
                        r_s     <= w_svar[DW-1:0];
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_k == 3'd0) begin
                        r_neg <= w_p_rd[DW-1];
                        r_k   <= 3'd1;
                    end else if (w_div_done) begin
                        r_gain[r_i] <= w_gain;
                        r_k         <= '0;
                        if (w_last_i) begin
                            r_i     <= '0;
                            r_state <= ST_INNOV;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                ST_INNOV: begin
                    r_innov <= kde_pkg::sat32(kde_pkg::ACC_W'(w_diff));
                    r_k     <= '0;
                    r_state <= ST_UPD_X;
                end
                ST_UPD_X: begin
                    if (w_store) begin
                        case (r_i)
                            2'd0:    r_pos <= w_sat;
                            2'd1:    r_vel <= w_sat;
                            default: r_acc <= w_sat;
                        endcase
                        if (w_last_i) begin
                            r_i     <= '0;
                            r_state <= ST_UPD_P;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                ST_UPD_P: begin
                    if (w_store) begin
                        r_p[w_ij] <= w_sat;
                        if (w_last_j) begin
                            r_j <= '0;
                            if (w_last_i) begin
                                r_i     <= '0;
                                r_state <= ST_ZERO_V;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                ST_ZERO_V: begin
                    if (w_still) begin
                        r_vel <= '0;
                    end
                    r_out_data  <= {r_acc, (w_still ? {DW{1'b0}} : r_vel), r_pos};
                    r_out_user  <= {r_skip, w_still};
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `KDE_ASSERT(a_ready_no_result, i_clk, i_rst_n, s_axis_tready |-> !m_axis_tvalid)
    `KDE_ASSERT(a_valid_in_out, i_clk, i_rst_n, m_axis_tvalid |-> (r_state == ST_OUT))
    `KDE_ASSERT(a_still_zero_vel, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == '0))
    `KDE_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div_done |-> (r_state == ST_DIV))
    `KDE_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule
